// File: design/gftl_pkg.sv
// gftl_pkg: shared constants for the grid field trilinear lookup
// register indexes, item function codes and default grid size
// no dependencies
`default_nettype none
package gftl_pkg;

  // default grid size per axis
  localparam int GRID_X_DEF = 16;
  localparam int GRID_Y_DEF = 16;
  localparam int GRID_Z_DEF = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CORNER_X    = 3'd0,
    REG_CORNER_Y    = 3'd1,
    REG_CORNER_Z    = 3'd2,
    REG_INV_PITCH_X = 3'd3,
    REG_INV_PITCH_Y = 3'd4,
    REG_INV_PITCH_Z = 3'd5,
    REG_FIELD_SCALE = 3'd6
  } cfg_reg_t;

  // register reset values
  localparam logic [31:0] INV_PITCH_RST   = 32'h0100_0000; // 1.0 in q8.24
  localparam logic [23:0] FIELD_SCALE_RST = 24'h0A_0000;   // 10.0 in q8.16

  // item function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

endpackage
`default_nettype wire

// File: design/grid_field_trilinear_lookup.sv
// throughput: one item per cycle; the only stall source is out_stall on a full output
// loads occupy a pipeline slot and write all corner banks when they pass the read stage
// reset (rst_n low, synchronous) clears all valid bits and the config registers;
// the grid stores hold no reset value and must be loaded before they are queried
// depends on gftl_pkg
`default_nettype none
module grid_field_trilinear_lookup #(
  parameter int GRID_X = gftl_pkg::GRID_X_DEF,
  parameter int GRID_Y = gftl_pkg::GRID_Y_DEF,
  parameter int GRID_Z = gftl_pkg::GRID_Z_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input items
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_func,
  input  wire logic signed [31:0]                  in_pos_x,
  input  wire logic signed [31:0]                  in_pos_y,
  input  wire logic signed [31:0]                  in_pos_z,
  input  wire logic        [11:0]                  in_grid_index,
  input  wire logic signed [31:0]                  in_sample_x,
  input  wire logic signed [31:0]                  in_sample_y,
  input  wire logic signed [31:0]                  in_sample_z,
  // result items
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [31:0]                       out_field_x,
  output logic signed [31:0]                       out_field_y,
  output logic signed [31:0]                       out_field_z,
  output logic                                     out_inside_res,
  // configuration writes
  input  wire logic                                cfg_we,
  input  wire logic [gftl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [gftl_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int DEPTH = GRID_X * GRID_Y * GRID_Z;
  localparam int AW    = $clog2(DEPTH);
  localparam int CXW   = $clog2(GRID_X);
  localparam int CYW   = $clog2(GRID_Y);
  localparam int CZW   = $clog2(GRID_Z);
  localparam int NST   = 12;  // pipeline stages, last one is the output register

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic signed [31:0] corner_x_r, corner_y_r, corner_z_r;
  logic        [31:0] inv_x_r, inv_y_r, inv_z_r;
  logic        [23:0] scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_x_r <= '0;
      corner_y_r <= '0;
      corner_z_r <= '0;
      inv_x_r    <= gftl_pkg::INV_PITCH_RST;
      inv_y_r    <= gftl_pkg::INV_PITCH_RST;
      inv_z_r    <= gftl_pkg::INV_PITCH_RST;
      scale_r    <= gftl_pkg::FIELD_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gftl_pkg::REG_CORNER_X:    corner_x_r <= cfg_data;
        gftl_pkg::REG_CORNER_Y:    corner_y_r <= cfg_data;
        gftl_pkg::REG_CORNER_Z:    corner_z_r <= cfg_data;
        gftl_pkg::REG_INV_PITCH_X: inv_x_r    <= cfg_data;
        gftl_pkg::REG_INV_PITCH_Y: inv_y_r    <= cfg_data;
        gftl_pkg::REG_INV_PITCH_Z: inv_z_r    <= cfg_data;
        gftl_pkg::REG_FIELD_SCALE: scale_r    <= cfg_data[23:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline control: every stage moves together unless the output item waits
  // ---------------------------------------------------------------------------
  logic vld_r [1:NST];
  logic qry_r [1:NST];
  logic adv;

  assign adv      = !(vld_r[NST] && qry_r[NST] && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= NST; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[1] <= in_valid;
      for (int s = 2; s <= NST; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qry_r[1] <= (in_func == gftl_pkg::FUNC_QUERY);
      for (int s = 2; s <= NST; s++) begin
        qry_r[s] <= qry_r[s-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: offset from grid corner, raw sample times scale
  // ---------------------------------------------------------------------------
  logic signed [32:0] d1x_r, d1y_r, d1z_r;
  logic signed [56:0] p1_r [3];
  logic        [11:0] gi_r [1:5];

  always_ff @(posedge clk) begin
    if (adv) begin
      d1x_r    <= {in_pos_x[31], in_pos_x} - {corner_x_r[31], corner_x_r};
      d1y_r    <= {in_pos_y[31], in_pos_y} - {corner_y_r[31], corner_y_r};
      d1z_r    <= {in_pos_z[31], in_pos_z} - {corner_z_r[31], corner_z_r};
      p1_r[0]  <= in_sample_x * $signed({1'b0, scale_r});
      p1_r[1]  <= in_sample_y * $signed({1'b0, scale_r});
      p1_r[2]  <= in_sample_z * $signed({1'b0, scale_r});
      gi_r[1]  <= in_grid_index;
      for (int s = 2; s <= 5; s++) begin
        gi_r[s] <= gi_r[s-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: offset times reciprocal pitch as two partial products;
  // load path rounds and saturates the scaled sample
  // ---------------------------------------------------------------------------
  logic        [48:0] ph2_r [3];
  logic        [47:0] pl2_r [3];
  logic               neg2_r [3];
  logic        [95:0] ldw_r [2:5];
  logic signed [32:0] d1 [3];
  logic        [31:0] inv [3];
  logic        [95:0] ldw_nxt;

  assign d1[0]  = d1x_r;
  assign d1[1]  = d1y_r;
  assign d1[2]  = d1z_r;
  assign inv[0] = inv_x_r;
  assign inv[1] = inv_y_r;
  assign inv[2] = inv_z_r;

  always_comb begin
    logic signed [57:0] rnd;
    logic signed [41:0] shf;
    ldw_nxt = '0;
    for (int m = 0; m < 3; m++) begin
      rnd = 58'(p1_r[m]) + 58'sd32768;
      shf = 42'(rnd >>> 16);
      if (shf > 42'sd2147483647) begin
        ldw_nxt[32*m +: 32] = 32'h7FFF_FFFF;
      end else if (shf < -42'sd2147483648) begin
        ldw_nxt[32*m +: 32] = 32'h8000_0000;
      end else begin
        ldw_nxt[32*m +: 32] = shf[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        ph2_r[a]  <= d1[a][32:16] * inv[a];
        pl2_r[a]  <= d1[a][15:0] * inv[a];
        neg2_r[a] <= d1[a][32];
      end
      ldw_r[2] <= ldw_nxt;
      for (int s = 3; s <= 5; s++) begin
        ldw_r[s] <= ldw_r[s-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: cell index, fraction and inside test per axis
  // ---------------------------------------------------------------------------
  logic [64:0]     u3 [3];
  logic            ok3 [3];
  logic [CXW-1:0]  cx3_r;
  logic [CYW-1:0]  cy3_r;
  logic [CZW-1:0]  cz3_r;
  logic [15:0]     frx_r [3:11][3];
  logic            ins_r [3:NST];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      u3[a] = {ph2_r[a], 16'b0} + {17'b0, pl2_r[a]};
    end
    ok3[0] = !neg2_r[0] && (u3[0][64:24] <= 41'(GRID_X - 2));
    ok3[1] = !neg2_r[1] && (u3[1][64:24] <= 41'(GRID_Y - 2));
    ok3[2] = !neg2_r[2] && (u3[2][64:24] <= 41'(GRID_Z - 2));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // outside points get cell zero so the addresses stay in range
      cx3_r    <= ok3[0] ? u3[0][24 +: CXW] : '0;
      cy3_r    <= ok3[1] ? u3[1][24 +: CYW] : '0;
      cz3_r    <= ok3[2] ? u3[2][24 +: CZW] : '0;
      ins_r[3] <= ok3[0] && ok3[1] && ok3[2];
      for (int a = 0; a < 3; a++) begin
        frx_r[3][a] <= u3[a][23:8];
      end
      for (int s = 4; s <= 11; s++) begin
        frx_r[s] <= frx_r[s-1];
      end
      for (int s = 4; s <= NST; s++) begin
        ins_r[s] <= ins_r[s-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stages 4 and 5: flat addresses of the eight corners
  // ---------------------------------------------------------------------------
  logic [AW-1:0]  base4_r;
  logic [CZW-1:0] cz4_r;
  logic [AW-1:0]  addr5_r [8];
  logic [AW-1:0]  row5;

  assign row5 = base4_r * AW'(GRID_Z) + AW'(cz4_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      base4_r <= AW'(cx3_r) * AW'(GRID_Y) + AW'(cy3_r);
      cz4_r   <= cz3_r;
      // corner bits: [2] x step, [1] y step, [0] z step
      for (int c = 0; c < 8; c++) begin
        addr5_r[c] <= row5 + AW'(((c >> 2) & 1) * GRID_Y * GRID_Z
                                 + ((c >> 1) & 1) * GRID_Z + (c & 1));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: eight replicated banks, one per corner; a load writes all of them
  // at the same stage where queries read, so item order is kept
  // ---------------------------------------------------------------------------
  logic [95:0]        mem_bank [8][DEPTH];
  logic signed [31:0] v6_r [3][8];
  logic               ld_wr;

  assign ld_wr = vld_r[5] && !qry_r[5] && (32'(gi_r[5]) < 32'(DEPTH));

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int b = 0; b < 8; b++) begin
        if (ld_wr) begin
          mem_bank[b][AW'(gi_r[5])] <= ldw_r[5];
        end
        for (int m = 0; m < 3; m++) begin
          v6_r[m][b] <= mem_bank[b][addr5_r[b]][32*m +: 32];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stages 7..12: lerp along x, y, z; each is a multiply stage then an add stage
  // ---------------------------------------------------------------------------
  logic signed [49:0] p7_r [3][4];
  logic signed [31:0] a7_r [3][4];
  logic signed [31:0] c8_r [3][4];
  logic signed [49:0] p9_r [3][2];
  logic signed [31:0] a9_r [3][2];
  logic signed [31:0] e10_r [3][2];
  logic signed [49:0] p11_r [3];
  logic signed [31:0] a11_r [3];
  logic signed [31:0] fld_r [3];
  logic               out_vld_r;
  logic               out_ins_r;

  always_ff @(posedge clk) begin
    logic signed [32:0] dif;
    logic signed [16:0] fs;
    if (adv) begin
      for (int m = 0; m < 3; m++) begin
        fs = $signed({1'b0, frx_r[6][0]});
        for (int q = 0; q < 4; q++) begin
          dif         = 33'(v6_r[m][4+q]) - 33'(v6_r[m][q]);
          p7_r[m][q] <= dif * fs;
          a7_r[m][q] <= v6_r[m][q];
        end
        for (int q = 0; q < 4; q++) begin
          c8_r[m][q] <= a7_r[m][q] + 32'(p7_r[m][q] >>> 16);
        end
        fs = $signed({1'b0, frx_r[8][1]});
        for (int k = 0; k < 2; k++) begin
          dif         = 33'(c8_r[m][2+k]) - 33'(c8_r[m][k]);
          p9_r[m][k] <= dif * fs;
          a9_r[m][k] <= c8_r[m][k];
        end
        for (int k = 0; k < 2; k++) begin
          e10_r[m][k] <= a9_r[m][k] + 32'(p9_r[m][k] >>> 16);
        end
        fs        = $signed({1'b0, frx_r[10][2]});
        dif       = 33'(e10_r[m][1]) - 33'(e10_r[m][0]);
        p11_r[m] <= dif * fs;
        a11_r[m] <= e10_r[m][0];
        // outside points give zero fields
        fld_r[m] <= ins_r[11] ? a11_r[m] + 32'(p11_r[m] >>> 16) : '0;
      end
    end
  end

  assign out_vld_r = vld_r[NST] && qry_r[NST];
  assign out_ins_r = ins_r[NST];

  assign out_valid      = out_vld_r;
  assign out_inside_res = out_ins_r;
  assign out_field_x    = fld_r[0];
  assign out_field_y    = fld_r[1];
  assign out_field_z    = fld_r[2];

endmodule
`default_nettype wire

// File: design/gftl_checker.sv
// gftl_props: port-level assertions for grid_field_trilinear_lookup
// bound to the top level; no package dependency
`default_nettype none
module gftl_props (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_field_x,
  input wire logic [31:0] out_field_y,
  input wire logic [31:0] out_field_z,
  input wire logic        out_inside_res
);

  // a waiting item stays on the output
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_field_x) && $stable(out_field_y)
      && $stable(out_field_z) && $stable(out_inside_res))
    else $error("output item changed while stalled");

  // outside points report zero fields
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_inside_res |-> out_field_x == 32'd0 && out_field_y == 32'd0
      && out_field_z == 32'd0)
    else $error("outside item with nonzero field");

  // input is held off exactly while a finished item waits
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall without a waiting output item");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind grid_field_trilinear_lookup gftl_props u_gftl_props (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_field_x    (out_field_x),
  .out_field_y    (out_field_y),
  .out_field_z    (out_field_z),
  .out_inside_res (out_inside_res)
);
`default_nettype wire

// File: tb/gftl_checker.sv
// gftl_checker: watches the item, result and register ports of the lookup block,
// predicts each query result and compares it with what the block returns
// depends on gftl_pkg
`timescale 1ns / 100ps
module gftl_checker #(
  parameter int GRID_X = gftl_pkg::GRID_X_DEF,
  parameter int GRID_Y = gftl_pkg::GRID_Y_DEF,
  parameter int GRID_Z = gftl_pkg::GRID_Z_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              in_func,
  input  logic signed [31:0]                in_pos_x,
  input  logic signed [31:0]                in_pos_y,
  input  logic signed [31:0]                in_pos_z,
  input  logic        [11:0]                in_grid_index,
  input  logic signed [31:0]                in_sample_x,
  input  logic signed [31:0]                in_sample_y,
  input  logic signed [31:0]                in_sample_z,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [31:0]                out_field_x,
  input  logic signed [31:0]                out_field_y,
  input  logic signed [31:0]                out_field_z,
  input  logic                              out_inside_res,
  input  logic                              cfg_we,
  input  logic [gftl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gftl_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                errors,
  output int                                pending
);

  localparam int DEPTH = GRID_X * GRID_Y * GRID_Z;

  typedef struct {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
    logic               in_grid;
  } field_t;

  logic signed [31:0] corner[3];
  logic        [31:0] inv_pitch[3];
  logic        [23:0] scale;
  logic signed [31:0] grid_store[3][DEPTH];
  field_t             field_q[$];

  function automatic logic signed [31:0] scale_sample(input logic signed [31:0] raw);
    longint p;
    p = ((longint'(raw) * longint'(scale)) + 64'sd32768) >>> 16;
    if (p > 64'sd2147483647) p = 64'sd2147483647;
    if (p < -64'sd2147483648) p = -64'sd2147483648;
    return p[31:0];
  endfunction

  // cell index and 16-bit fraction along one axis, 0 when outside
  function automatic bit locate_axis(input logic signed [31:0] pos,
                                     input logic signed [31:0] crn,
                                     input logic [31:0] inv, input int grid,
                                     output int cell_idx, output longint frac);
    longint      d;
    logic [64:0] u;
    cell_idx = 0;
    frac = 0;
    d = longint'(pos) - longint'(crn);
    if (d < 0) return 0;
    u = 65'(d) * 65'(inv);
    if (u[64:24] > 41'(grid - 2)) return 0;
    cell_idx = int'(u[64:24]);
    frac = longint'(u[23:8]);
    return 1;
  endfunction

  function automatic longint lerp(input longint a, input longint b, input longint f);
    return a + (((b - a) * f) >>> 16);
  endfunction

  function automatic logic signed [31:0] trilerp(input int comp, input int ix,
                                                 input int iy, input int iz,
                                                 input longint fx, input longint fy,
                                                 input longint fz);
    longint v[2][2][2];
    longint c[2][2];
    longint e[2];
    longint r;
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        for (int k = 0; k < 2; k++)
          v[i][j][k] = longint'(grid_store[comp][((ix + i) * GRID_Y + iy + j) * GRID_Z
                                                 + iz + k]);
    for (int j = 0; j < 2; j++)
      for (int k = 0; k < 2; k++)
        c[j][k] = lerp(v[0][j][k], v[1][j][k], fx);
    for (int k = 0; k < 2; k++)
      e[k] = lerp(c[0][k], c[1][k], fy);
    r = lerp(e[0], e[1], fz);
    return r[31:0];
  endfunction

  function automatic field_t predict_field(input logic signed [31:0] px,
                                           input logic signed [31:0] py,
                                           input logic signed [31:0] pz);
    field_t r;
    int     ix, iy, iz;
    longint fx, fy, fz;
    r = '{fx: 0, fy: 0, fz: 0, in_grid: 1'b0};
    if (locate_axis(px, corner[0], inv_pitch[0], GRID_X, ix, fx) &&
        locate_axis(py, corner[1], inv_pitch[1], GRID_Y, iy, fy) &&
        locate_axis(pz, corner[2], inv_pitch[2], GRID_Z, iz, fz)) begin
      r.fx = trilerp(0, ix, iy, iz, fx, fy, fz);
      r.fy = trilerp(1, ix, iy, iz, fx, fy, fz);
      r.fz = trilerp(2, ix, iy, iz, fx, fy, fz);
      r.in_grid = 1'b1;
    end
    return r;
  endfunction

  assign pending = field_q.size();

  initial errors = 0;

  always @(posedge clk) begin
    field_t got;
    field_t want;
    if (!rst_n) begin
      corner = '{0, 0, 0};
      inv_pitch = '{gftl_pkg::INV_PITCH_RST, gftl_pkg::INV_PITCH_RST,
                    gftl_pkg::INV_PITCH_RST};
      scale = gftl_pkg::FIELD_SCALE_RST;
      field_q.delete();
    end else begin
      if (cfg_we) begin
        case (gftl_pkg::cfg_reg_t'(cfg_index))
          gftl_pkg::REG_CORNER_X:    corner[0] = cfg_data;
          gftl_pkg::REG_CORNER_Y:    corner[1] = cfg_data;
          gftl_pkg::REG_CORNER_Z:    corner[2] = cfg_data;
          gftl_pkg::REG_INV_PITCH_X: inv_pitch[0] = cfg_data;
          gftl_pkg::REG_INV_PITCH_Y: inv_pitch[1] = cfg_data;
          gftl_pkg::REG_INV_PITCH_Z: inv_pitch[2] = cfg_data;
          gftl_pkg::REG_FIELD_SCALE: scale = cfg_data[23:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_func == gftl_pkg::FUNC_LOAD) begin
          if (in_grid_index < DEPTH) begin
            grid_store[0][in_grid_index] = scale_sample(in_sample_x);
            grid_store[1][in_grid_index] = scale_sample(in_sample_y);
            grid_store[2][in_grid_index] = scale_sample(in_sample_z);
          end
        end else begin
          field_q.push_back(predict_field(in_pos_x, in_pos_y, in_pos_z));
        end
      end
      if (out_valid && !out_stall) begin
        got = '{fx: out_field_x, fy: out_field_y, fz: out_field_z,
                in_grid: out_inside_res};
        if (field_q.size() == 0) begin
          $error("unexpected result item: field_x %0d", got.fx);
          errors++;
        end else begin
          want = field_q.pop_front();
          if (got.fx !== want.fx) begin
            $error("field_x expected %0d actual %0d", want.fx, got.fx);
            errors++;
          end
          if (got.fy !== want.fy) begin
            $error("field_y expected %0d actual %0d", want.fy, got.fy);
            errors++;
          end
          if (got.fz !== want.fz) begin
            $error("field_z expected %0d actual %0d", want.fz, got.fz);
            errors++;
          end
          if (got.in_grid !== want.in_grid) begin
            $error("inside_res expected %0b actual %0b", want.in_grid, got.in_grid);
            errors++;
          end
        end
      end
    end
  end

endmodule

// File: tb/testbench.sv
// testbench: drives load and query items and register writes into the grid
// field lookup, with random idling on both channels; verdict from gftl_checker
// depends on gftl_pkg, grid_field_trilinear_lookup and gftl_checker
`timescale 1ns / 100ps
module testbench;

  localparam int GX = gftl_pkg::GRID_X_DEF;
  localparam int GY = gftl_pkg::GRID_Y_DEF;
  localparam int GZ = gftl_pkg::GRID_Z_DEF;
  localparam int DEPTH = GX * GY * GZ;
  localparam int SUB = 8;  // loaded low block per axis, cells 0 .. SUB-2 usable
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 110;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_func = gftl_pkg::FUNC_LOAD;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic [11:0] in_grid_index = '0;
  logic signed [31:0] in_sample_x = '0, in_sample_y = '0, in_sample_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_field_x, out_field_y, out_field_z;
  logic out_inside_res;
  logic cfg_we = 1'b0;
  logic [gftl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [gftl_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int errors;
  int pending;
  int cycles = 0;
  int queries = 0;
  int loads = 0;
  bit calm = 1'b0;     // no idling in the closing part of the run
  // current register copy, used to aim queries into the grid
  logic signed [31:0] corner_cur[3];
  logic [31:0] pitch_cur[3];

  always #5 clk = ~clk;

  grid_field_trilinear_lookup u_top (.*);

  gftl_checker #(.GRID_X(GX), .GRID_Y(GY), .GRID_Z(GZ)) u_checker (.*);

  // hard limit on run length
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // result side stalls in random bursts, except in the calm closing part
  always @(posedge clk) begin
    int hold;
    if (hold > 0) begin
      hold = hold - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      hold = $urandom_range(0, 20);
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      hold = $urandom_range(0, 14);
    end
  end

  // present one item and hold it until the block takes it
  task automatic send_item(input logic func, input logic signed [31:0] px,
                           input logic signed [31:0] py, input logic signed [31:0] pz,
                           input logic [11:0] gidx, input logic signed [31:0] sx,
                           input logic signed [31:0] sy, input logic signed [31:0] sz);
    bit taken;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_pos_x <= px;
    in_pos_y <= py;
    in_pos_z <= pz;
    in_grid_index <= gidx;
    in_sample_x <= sx;
    in_sample_y <= sy;
    in_sample_z <= sz;
    if (func == gftl_pkg::FUNC_LOAD) loads++;
    else queries++;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic send_load(input logic [11:0] gidx, input logic signed [31:0] sx,
                           input logic signed [31:0] sy, input logic signed [31:0] sz);
    send_item(gftl_pkg::FUNC_LOAD, $urandom, $urandom, $urandom, gidx, sx, sy, sz);
  endtask

  task automatic send_query(input logic signed [31:0] px, input logic signed [31:0] py,
                            input logic signed [31:0] pz);
    send_item(gftl_pkg::FUNC_QUERY, px, py, pz, 12'($urandom), $urandom, $urandom,
              $urandom);
  endtask

  // coordinate aimed at a random spot inside the grid along one axis
  function automatic logic signed [31:0] aim_axis(input int a, input int grid);
    longint target;
    longint d;
    target = longint'($urandom_range(0, (grid - 1) * 256 - 1)) << 16
             | longint'($urandom_range(0, 65535));
    if (pitch_cur[a] == 0) d = longint'($urandom_range(0, 1000));
    else d = target / longint'(pitch_cur[a]);
    return 32'(longint'(corner_cur[a]) + d);
  endfunction

  // true when a point inside the grid would read a corner that was never loaded;
  // loaded are the low block and the top corner cell
  function automatic bit hits_unloaded(input logic signed [31:0] px,
                                       input logic signed [31:0] py,
                                       input logic signed [31:0] pz);
    logic signed [31:0] p[3];
    int          g[3];
    longint      d;
    logic [64:0] u;
    bit          low_ok;
    bit          top_ok;
    p = '{px, py, pz};
    g = '{GX, GY, GZ};
    low_ok = 1'b1;
    top_ok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      d = longint'(p[a]) - longint'(corner_cur[a]);
      if (d < 0) return 1'b0;
      u = 65'(d) * 65'(pitch_cur[a]);
      if (u[64:24] > 41'(g[a] - 2)) return 1'b0;
      if (u[64:24] > 41'(SUB - 2)) low_ok = 1'b0;
      if (u[64:24] != 41'(g[a] - 2)) top_ok = 1'b0;
    end
    return !(low_ok || top_ok);
  endfunction

  // leaves the write enable high; the caller drops it after the last write
  task automatic write_reg(input gftl_pkg::cfg_reg_t idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    if (idx <= gftl_pkg::REG_CORNER_Z) corner_cur[idx] = value;
    else if (idx <= gftl_pkg::REG_INV_PITCH_Z)
      pitch_cur[idx - gftl_pkg::REG_INV_PITCH_X] = value;
  endtask

  // wait for the pipeline to drain, loads included, before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    logic [31:0] c_val, p_val;
    logic signed [31:0] qx, qy, qz;
    int pick;
    int ix, iy, iz;
    corner_cur = '{0, 0, 0};
    pitch_cur = '{gftl_pkg::INV_PITCH_RST, gftl_pkg::INV_PITCH_RST,
                  gftl_pkg::INV_PITCH_RST};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // load the low block and the top corner cell; queries stay in cells whose
    // corners are all loaded; the first few samples hit the saturation limits
    for (int i = 0; i < DEPTH; i++) begin
      ix = i / (GY * GZ);
      iy = (i / GZ) % GY;
      iz = i % GZ;
      if ((ix < SUB && iy < SUB && iz < SUB) ||
          (ix >= GX - 2 && iy >= GY - 2 && iz >= GZ - 2)) begin
        if (i == 0) send_load(0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
        else if (i == 1) send_load(1, 32'sh8000_0000, 32'sh7FFF_FFFF, -1);
        else if (i == 2) send_load(2, 32'sh0CCC_CCCC, -32'sh0CCC_CCCD, 1);
        else send_load(12'(i), $urandom, $urandom, $urandom);
      end
    end

    // directed queries at default registers: corner cells, the outer edge,
    // just below the corner, and the coordinate extremes
    send_query(0, 0, 0);
    send_query(GX - 2, GY - 2, GZ - 2);
    send_query(GX - 1, 0, 0);
    send_query(0, GY - 1, 0);
    send_query(0, 0, GZ - 1);
    send_query(-1, 5, 5);
    send_query(5, -1, 5);
    send_query(5, 5, -1);
    send_query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_query(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_query(SUB - 3, 3, SUB - 2);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      for (int a = 0; a < 3; a++) begin
        case (ph)
          0: begin  // pitch of 256 units, so fractions appear
            c_val = 32'($urandom_range(0, 1000)) - 500;
            p_val = 32'h0001_0000;
          end
          1: begin  // lowest corner, largest reciprocal pitch
            c_val = 32'h8000_0000;
            p_val = 32'hFFFF_FFFF;
          end
          2: begin  // highest corner with zero pitch: cell 0 or outside
            c_val = 32'h7FFF_FC00;
            p_val = 32'h0000_0000;
          end
          3: begin  // smallest nonzero reciprocal pitch over the full coordinate span
            c_val = 32'h8000_0000;
            p_val = 32'h0000_0001;
          end
          default: begin
            c_val = $urandom;
            p_val = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 32'h0010_0000);
          end
        endcase
        write_reg(gftl_pkg::cfg_reg_t'(gftl_pkg::REG_CORNER_X + a), c_val);
        write_reg(gftl_pkg::cfg_reg_t'(gftl_pkg::REG_INV_PITCH_X + a), p_val);
      end
      case (ph)
        1: write_reg(gftl_pkg::REG_FIELD_SCALE, 24'hFF_FFFF);
        2: write_reg(gftl_pkg::REG_FIELD_SCALE, 24'h00_0000);
        5: write_reg(gftl_pkg::REG_FIELD_SCALE, gftl_pkg::FIELD_SCALE_RST);
        default: write_reg(gftl_pkg::REG_FIELD_SCALE, 24'($urandom));
      endcase
      cfg_we <= 1'b0;
      if (ph == PHASES - 1) calm = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          send_query(aim_axis(0, SUB), aim_axis(1, SUB), aim_axis(2, SUB));
        end else if (pick < 82) begin
          do begin
            qx = $urandom;
            qy = $urandom;
            qz = $urandom;
          end while (hits_unloaded(qx, qy, qz));
          send_query(qx, qy, qz);
        end else if (pick < 86) begin
          do begin
            qx = aim_axis(0, SUB);
            qy = $urandom;
            qz = aim_axis(2, SUB);
          end while (hits_unloaded(qx, qy, qz));
          send_query(qx, qy, qz);
        end else begin
          send_load(12'($urandom), $urandom, $urandom, $urandom);
        end
      end
    end

    drain();
    $display("run covered %0d loads and %0d queries over %0d register settings",
             loads, queries, PHASES + 1);
    $display("extreme corners, pitches and scales included; %0d mismatches", errors);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
design/gftl_pkg.sv
design/grid_field_trilinear_lookup.sv
design/gftl_checker.sv
tb/gftl_checker.sv
tb/testbench.sv
